/* rtl/core/assert_macros.svh */
// Assertion macros shared by the queue RTL.
// Clocked property checks with and without a reset qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/spq_pkg.sv */
// Package for the sorted priority queue: sizes, codes and the cell control struct.
// No dependencies.
`default_nettype none
package spq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned PRIO_WIDTH = 16;
  localparam int unsigned OCC_W      = 5;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  localparam int unsigned IN_DATA_W  = ((ELEM_WIDTH + PRIO_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((ELEM_WIDTH + PRIO_WIDTH + OCC_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = 3;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                  push;
    logic                  pop;
    logic [ELEM_WIDTH-1:0] elem;
    logic [PRIO_WIDTH-1:0] prio;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/spq_cell.sv */
// One storage cell of the sorted queue chain: holds an entry, shifts toward either neighbor.
// Depends on spq_pkg.
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire                  clk_i,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire                  valid_i,
  input  wire                  left_ge_i,
  input  wire [ELEM_WIDTH-1:0] left_elem_i,
  input  wire [PRIO_WIDTH-1:0] left_prio_i,
  input  wire [ELEM_WIDTH-1:0] right_elem_i,
  input  wire [PRIO_WIDTH-1:0] right_prio_i,
  output logic                 ge_o,
  output logic [ELEM_WIDTH-1:0] elem_o,
  output logic [PRIO_WIDTH-1:0] prio_o
);

  logic [ELEM_WIDTH-1:0] elem_q, elem_d;
  logic [PRIO_WIDTH-1:0] prio_q, prio_d;

  // empty cells always count as an insertion point
  assign ge_o = !valid_i || (prio_q <= ctrl_i.prio);

  always_comb begin
    elem_d = elem_q;
    prio_d = prio_q;
    if (ctrl_i.push && ge_o) begin
      if (left_ge_i) begin
        elem_d = left_elem_i;
        prio_d = left_prio_i;
      end else begin
        elem_d = ctrl_i.elem;
        prio_d = ctrl_i.prio;
      end
    end else if (ctrl_i.pop) begin
      elem_d = right_elem_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    prio_q <= prio_d;
  end

  assign elem_o = elem_q;
  assign prio_o = prio_q;

endmodule
`default_nettype wire

/* rtl/core/sorted_priority_queue.sv */
// Top level of the sorted priority queue: entry counter, cell chain, result register.
// Depends on spq_pkg, spq_cell and assert_macros.svh.
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | element[31:0] priority_req[47:32]        | cmd[0]
//  m_axis   | out | out_element[31:0] out_priority[47:32]    | out_valid[0] status[2:1]
//           |     | occupancy[52:48]                         |
//
// One request per cycle while no result is stalled; the result is registered and appears in the cycle after acceptance.
// All cells compare against the pushed priority in parallel and shift together.
// Reset clears the entry count; the cell contents are only read below the count.
// A stalled result holds the output register; s_axis_tready_o drops only while
// a result waits and m_axis_tready_i is low.
`default_nettype none
`include "assert_macros.svh"
module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire [IN_DATA_W-1:0]   s_axis_tdata_i,  // element, priority_req
  input  wire                   s_axis_tuser_i,  // cmd
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // out_element, out_priority, occupancy
  output logic [OUT_USER_W-1:0] m_axis_tuser_o   // out_valid, status
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_vld_q;
  logic [ELEM_WIDTH-1:0] res_elem_q;
  logic [PRIO_WIDTH-1:0] res_prio_q;
  logic             res_valid_q;
  status_e          res_status_q, status_d;
  logic [OCC_W-1:0] res_occ_q;

  logic       accept;
  logic       is_pop, full, empty, push_ok, pop_ok;
  cell_ctrl_t ctrl;

  logic [ELEM_WIDTH-1:0] elem_w [DEPTH];
  logic [PRIO_WIDTH-1:0] prio_w [DEPTH];
  logic [DEPTH-1:0]      ge_w;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_pop  = (cmd_e'(s_axis_tuser_i) == CMD_POP);
  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign push_ok = accept && !is_pop && !full;
  assign pop_ok  = accept && is_pop && !empty;

  assign ctrl.push = push_ok;
  assign ctrl.pop  = pop_ok;
  assign ctrl.elem = s_axis_tdata_i[ELEM_WIDTH-1:0];
  assign ctrl.prio = s_axis_tdata_i[ELEM_WIDTH +: PRIO_WIDTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                  left_ge;
    logic [ELEM_WIDTH-1:0] left_elem, right_elem;
    logic [PRIO_WIDTH-1:0] left_prio, right_prio;

    if (g == 0) begin : g_head
      assign left_ge   = 1'b0;
      assign left_elem = '0;
      assign left_prio = '0;
    end else begin : g_mid
      assign left_ge   = ge_w[g-1];
      assign left_elem = elem_w[g-1];
      assign left_prio = prio_w[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_elem = elem_w[g];
      assign right_prio = prio_w[g];
    end else begin : g_body
      assign right_elem = elem_w[g+1];
      assign right_prio = prio_w[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (count_q > CNT_W'(g)),
      .left_ge_i    (left_ge),
      .left_elem_i  (left_elem),
      .left_prio_i  (left_prio),
      .right_elem_i (right_elem),
      .right_prio_i (right_prio),
      .ge_o         (ge_w[g]),
      .elem_o       (elem_w[g]),
      .prio_o       (prio_w[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    status_d = STAT_OK;
    if (is_pop && empty) begin
      status_d = STAT_EMPTY;
    end else if (!is_pop && full) begin
      status_d = STAT_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_elem_q   <= pop_ok ? elem_w[0] : '0;
      res_prio_q   <= pop_ok ? prio_w[0] : '0;
      res_valid_q  <= pop_ok;
      res_status_q <= status_d;
      res_occ_q    <= OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[ELEM_WIDTH-1:0] = res_elem_q;
    m_axis_tdata_o[ELEM_WIDTH +: PRIO_WIDTH] = res_prio_q;
    m_axis_tdata_o[ELEM_WIDTH + PRIO_WIDTH +: OCC_W] = res_occ_q;
  end

  assign m_axis_tuser_o = {res_status_q, res_valid_q};

  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "entry count over depth")
  `ASSERT_CLK(a_count_hold, clk_i, rst_ni, !accept |=> $stable(count_q), "count moved when idle")
  `ASSERT_CLK(a_full_drop, clk_i, rst_ni, (accept && !is_pop && full) |=> (m_axis_tuser_o == {STAT_FULL, 1'b0}) && (count_q == CNT_W'(DEPTH)), "full push not dropped")
  `ASSERT_CLK(a_pop_head, clk_i, rst_ni, pop_ok |=> res_valid_q && (res_prio_q == $past(prio_w[0])), "pop lost the head")
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result valid in reset")

endmodule
`default_nettype wire

/* tb/spq_order_checker.sv */
`timescale 1ns / 100ps
// Order checker for the sorted priority queue: tracks the expected contents
// from accepted requests and compares every accepted result field by field.
// Depends on spq_pkg.
module spq_order_checker
  import spq_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_tvalid_i,
  input  wire                   s_tready_i,
  input  wire [IN_DATA_W-1:0]   s_tdata_i,   // element, priority_req
  input  wire                   s_tuser_i,   // cmd
  input  wire                   m_tvalid_i,
  input  wire                   m_tready_i,
  input  wire [OUT_DATA_W-1:0]  m_tdata_i,   // out_element, out_priority, occupancy
  input  wire [OUT_USER_W-1:0]  m_tuser_i,   // out_valid, status
  output int                    fail_cnt_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [ELEM_WIDTH-1:0] elem;
    logic [PRIO_WIDTH-1:0] prio;
    logic                  valid;
    status_e               status;
    logic [OCC_W-1:0]      occ;
  } queue_result_t;

  logic [ELEM_WIDTH-1:0] elem_store [DEPTH];
  logic [PRIO_WIDTH-1:0] prio_store [DEPTH];
  int unsigned           entries;
  queue_result_t         expected_q [$];
  int                    fails;

  // Sorted insert ahead of the first entry with priority <= new one; pop takes the head.
  function automatic queue_result_t apply_request(cmd_e cmd, logic [ELEM_WIDTH-1:0] elem,
                                                  logic [PRIO_WIDTH-1:0] prio);
    queue_result_t r;
    int unsigned   pos;
    r = '0;
    r.status = STAT_OK;
    if (cmd == CMD_PUSH) begin
      if (entries >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        pos = entries;
        for (int i = 0; i < int'(entries); i++) begin
          if (pos == entries && prio_store[i] <= prio) pos = i;
        end
        for (int i = int'(entries); i > int'(pos); i--) begin
          elem_store[i] = elem_store[i-1];
          prio_store[i] = prio_store[i-1];
        end
        elem_store[pos] = elem;
        prio_store[pos] = prio;
        entries++;
      end
    end else if (entries == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.elem  = elem_store[0];
      r.prio  = prio_store[0];
      r.valid = 1'b1;
      for (int i = 1; i < int'(entries); i++) begin
        elem_store[i-1] = elem_store[i];
        prio_store[i-1] = prio_store[i];
      end
      entries--;
    end
    r.occ = OCC_W'(entries);
    return r;
  endfunction

  task automatic check_field(string name, logic [ELEM_WIDTH-1:0] want,
                             logic [ELEM_WIDTH-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      entries = 0;
      fails = 0;
      expected_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        expected_q.push_back(apply_request(cmd_e'(s_tuser_i), s_tdata_i[ELEM_WIDTH-1:0],
                                           s_tdata_i[ELEM_WIDTH +: PRIO_WIDTH]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no request pending");
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_element", want.elem, m_tdata_i[ELEM_WIDTH-1:0]);
          check_field("out_priority", want.prio, m_tdata_i[ELEM_WIDTH +: PRIO_WIDTH]);
          check_field("out_valid", want.valid, m_tuser_i[0]);
          check_field("status", want.status, m_tuser_i[2:1]);
          check_field("occupancy", want.occ, m_tdata_i[ELEM_WIDTH+PRIO_WIDTH +: OCC_W]);
        end
      end
      fail_cnt_o <= fails;
      pending_o  <= expected_q.size();
    end
  end

endmodule

/* tb/tb_sorted_priority_queue.sv */
`timescale 1ns / 100ps
// Testbench top for sorted_priority_queue: clock, reset, push/pop stimulus with
// random idling on both streams, and the verdict. Depends on spq_pkg, sorted_priority_queue, spq_order_checker.
module tb_sorted_priority_queue
  import spq_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_ITEMS  = 1450;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = CMD_PUSH;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  int                    fail_cnt;
  int                    pending;
  int unsigned           cycle_cnt = 0;
  int unsigned           send_max_gap = 16;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  sorted_priority_queue dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  spq_order_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  task automatic send_request(cmd_e cmd, logic [ELEM_WIDTH-1:0] elem,
                              logic [PRIO_WIDTH-1:0] prio);
    int unsigned gap;
    gap = $urandom_range(0, send_max_gap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({prio, elem});
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: per-result stall, runs with no stall, two long hold-offs.
  initial begin
    int unsigned results;
    int unsigned max_gap;
    int unsigned gap;
    results = 0;
    max_gap = 16;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (results % 32 == 0) max_gap = ($urandom_range(0, 3) == 0) ? 0 : 16;
      gap = (results == 300 || results == 900) ? 150 : $urandom_range(0, max_gap);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      results++;
    end
  end

  initial begin
    cmd_e                  cmd;
    logic [PRIO_WIDTH-1:0] prio;
    int unsigned           push_pct;
    int unsigned           pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pop on empty, extreme fields, ties at both ends, fill, push when full, pops
    send_request(CMD_POP, '1, '1);
    send_request(CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(CMD_PUSH, 32'h0000_0000, 16'h0000);
    send_request(CMD_PUSH, 32'h0000_0001, 16'h0000);
    send_request(CMD_PUSH, 32'h0000_0002, 16'hFFFF);
    for (int i = 0; i < 12; i++) begin
      send_request(CMD_PUSH, $urandom, 16'h8000 | PRIO_WIDTH'(i % 3));
    end
    send_request(CMD_PUSH, 32'hA5A5_A5A5, 16'hFFFF);
    repeat (4) send_request(CMD_POP, $urandom, PRIO_WIDTH'($urandom));

    push_pct = 50;
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n % 24 == 0) begin
        pick = $urandom_range(0, 2);
        push_pct = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
        send_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 16;
      end
      if (n == 700) drain();
      cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
      pick = $urandom_range(0, 9);
      if (pick < 5) prio = PRIO_WIDTH'($urandom_range(0, 7));
      else if (pick < 7) prio = $urandom_range(0, 1) ? '1 : '0;
      else prio = PRIO_WIDTH'($urandom);
      send_request(cmd, $urandom, prio);
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

/* sorted_priority_queue.f */
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
tb/spq_order_checker.sv
tb/tb_sorted_priority_queue.sv
